// File: rtl/core/slcfd_pkg.sv
package slcfd_pkg;

   localparam logic [15:0] SYNC_RESET = 16'hA55A;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_TOP    = 16'h8000;
   localparam logic [15:0] MIN_LENGTH = 16'd3;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN_HI  = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_TYPE    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CRC_HI  = 3'd5;
   localparam logic [2:0] PH_CRC_LO  = 3'd6;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  prev_byte;
      logic        prev_valid;
      logic [15:0] inner_length;
      logic [15:0] bytes_left;
      logic [7:0]  held_type;
      logic [15:0] running_crc;
      logic [7:0]  crc_high_byte;
   } dec_state_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  data;
      logic [7:0]  frame_type;
      logic        is_end;
      logic        crc_ok;
      logic [15:0] payload_len;
   } dec_result_type;

   localparam dec_state_type STATE_RESET = '{
      phase:         PH_HUNT,
      prev_byte:     8'd0,
      prev_valid:    1'b0,
      inner_length:  16'd0,
      bytes_left:    16'd0,
      held_type:     8'd0,
      running_crc:   CRC_INIT,
      crc_high_byte: 8'd0
   };

   // CRC-16-CCITT, MSB first, one byte: eight shift steps on a 16-bit value.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'd0};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'd0) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/sync_length_crc_frame_decoder_unit.sv
// Sync word, length and CRC-16 frame decoder.
//
// The request channel carries one received byte per item (req_in_byte). The
// decoder hunts for the two-byte sync word held in the csr_ register, reads
// a big-endian inner length, the type byte, the payload and a big-endian
// CRC-16-CCITT over type and payload. Every payload byte leaves at once as
// a response item with rsp_is_end low; the second CRC byte produces a final
// item with rsp_is_end high, rsp_crc_ok and rsp_payload_len. Downstream is
// expected to discard a frame whose end item has rsp_crc_ok low. Bytes that
// fall outside a frame produce no item.
//
// Each response item is registered as its byte is accepted. One item is
// accepted every cycle while req_stall is low; the CRC update is a single
// unrolled byte step, so only req_stall limits the rate. When the receiver
// stalls, the response register holds its item and a one-entry skid
// register takes one more result; req_stall rises only when that skid entry
// is occupied. Synchronous reset returns the decoder to the hunt with an
// empty window, empties both output registers and restores the default sync
// word. The sync word should only be written while idle.
module sync_length_crc_frame_decoder_unit
   import slcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data,
   output logic [7:0]  rsp_frame_type,
   output logic        rsp_is_end,
   output logic        rsp_crc_ok,
   output logic [15:0] rsp_payload_len,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0]    sync_ff;
   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_result_type result;
   dec_result_type out_ff;
   dec_result_type out_in;
   dec_result_type skid_ff;
   dec_result_type skid_in;
   logic           accept;
   logic           out_free;

   slcfd_decode u_decode (
      .state    (state_ff),
      .sync_word(sync_ff),
      .in_byte  (req_in_byte),
      .state_in (state_in),
      .result   (result)
   );

   // A new byte is refused only while the skid entry is full.
   assign req_stall = skid_ff.valid;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_ff.valid || !rsp_stall;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (out_free) begin
         if (skid_ff.valid) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end else begin
            out_in       = result;
            out_in.valid = accept && result.valid;
         end
      end else if (accept && result.valid) begin
         // The response register is held by the receiver: park the result.
         skid_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= SYNC_RESET;
         state_ff      <= STATE_RESET;
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            sync_ff <= csr_write_data;
         end
         if (accept) begin
            state_ff <= state_in;
         end
         out_ff.valid  <= out_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
      // Payload parts of the output registers carry no reset.
      out_ff.data         <= out_in.data;
      out_ff.frame_type   <= out_in.frame_type;
      out_ff.is_end       <= out_in.is_end;
      out_ff.crc_ok       <= out_in.crc_ok;
      out_ff.payload_len  <= out_in.payload_len;
      skid_ff.data        <= skid_in.data;
      skid_ff.frame_type  <= skid_in.frame_type;
      skid_ff.is_end      <= skid_in.is_end;
      skid_ff.crc_ok      <= skid_in.crc_ok;
      skid_ff.payload_len <= skid_in.payload_len;
   end

   assign rsp_valid       = out_ff.valid;
   assign rsp_data        = out_ff.data;
   assign rsp_frame_type  = out_ff.frame_type;
   assign rsp_is_end      = out_ff.is_end;
   assign rsp_crc_ok      = out_ff.crc_ok;
   assign rsp_payload_len = out_ff.payload_len;

   // The skid entry is only ever filled behind a held response.
   assert property (@(posedge clock) disable iff (reset) skid_ff.valid |-> out_ff.valid)
      else $error("skid entry occupied while response register empty");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_ff.valid) |-> $past(out_ff.valid && rsp_stall))
      else $error("skid entry filled without a stalled response");

   // The payload phase is entered and kept only while bytes remain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_PAYLOAD) |-> (state_ff.bytes_left != 16'd0))
      else $error("payload phase with no bytes left");

   // An end item always follows a second CRC byte and returns to the hunt.
   assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_CRC_LO)
         |=> (state_ff.phase == PH_HUNT && !state_ff.prev_valid))
      else $error("frame end did not restart the hunt");

endmodule

// File: rtl/core/slcfd_decode.sv
module slcfd_decode
   import slcfd_pkg::*;
(
   input  dec_state_type  state,
   input  logic [15:0]    sync_word,
   input  logic [7:0]     in_byte,
   output dec_state_type  state_in,
   output dec_result_type result
);

   logic [15:0] length_full;
   logic [15:0] window;

   assign length_full = {state.inner_length[15:8], in_byte};
   assign window      = {state.prev_byte, in_byte};

   always_comb begin
      state_in = state;
      result   = '0;
      unique case (state.phase)
         PH_LEN_HI: begin
            state_in.inner_length = {in_byte, 8'd0};
            state_in.phase        = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            state_in.inner_length = length_full;
            if (length_full < MIN_LENGTH) begin
               // Short length: the length bytes themselves re-enter the hunt.
               if (length_full == sync_word) begin
                  state_in.phase      = PH_LEN_HI;
                  state_in.prev_valid = 1'b0;
               end else begin
                  state_in.phase      = PH_HUNT;
                  state_in.prev_byte  = in_byte;
                  state_in.prev_valid = 1'b1;
               end
            end else begin
               state_in.bytes_left  = length_full - MIN_LENGTH;
               state_in.running_crc = CRC_INIT;
               state_in.phase       = PH_TYPE;
            end
         end
         PH_TYPE: begin
            state_in.held_type   = in_byte;
            state_in.running_crc = crc_byte(state.running_crc, in_byte);
            state_in.phase       = (state.bytes_left != 16'd0) ? PH_PAYLOAD : PH_CRC_HI;
         end
         PH_PAYLOAD: begin
            state_in.running_crc = crc_byte(state.running_crc, in_byte);
            state_in.bytes_left  = state.bytes_left - 16'd1;
            if (state.bytes_left == 16'd1) begin
               state_in.phase = PH_CRC_HI;
            end
            result.valid      = 1'b1;
            result.data       = in_byte;
            result.frame_type = state.held_type;
         end
         PH_CRC_HI: begin
            state_in.crc_high_byte = in_byte;
            state_in.phase         = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            result.valid       = 1'b1;
            result.frame_type  = state.held_type;
            result.is_end      = 1'b1;
            result.crc_ok      = ({state.crc_high_byte, in_byte} == state.running_crc);
            result.payload_len = state.inner_length - MIN_LENGTH;
            state_in.phase      = PH_HUNT;
            state_in.prev_valid = 1'b0;
         end
         default: begin
            // Hunt, and any unused phase code, slides the two-byte window.
            if (state.prev_valid && (window == sync_word)) begin
               state_in.phase      = PH_LEN_HI;
               state_in.prev_valid = 1'b0;
            end else begin
               state_in.phase      = PH_HUNT;
               state_in.prev_byte  = in_byte;
               state_in.prev_valid = 1'b1;
            end
         end
      endcase
   end

endmodule

// File: tb/tb_sync_length_crc_frame_decoder_unit.sv
`timescale 1ns / 1ps

// Testbench for the sync word, length and CRC-16 frame decoder.
module tb_sync_length_crc_frame_decoder_unit
   import slcfd_pkg::*;
();

   // One decoded item as the response channel presents it.
   typedef struct {
      logic [7:0]  data;
      logic [7:0]  frame_type;
      logic        is_end;
      logic        crc_ok;
      logic [15:0] payload_len;
   } deframed_type;

   typedef logic [7:0] octet_q_type [$];

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte      = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_data;
   logic [7:0]  rsp_frame_type;
   logic        rsp_is_end;
   logic        rsp_crc_ok;
   logic [15:0] rsp_payload_len;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = 16'h0000;

   sync_length_crc_frame_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_is_end       (rsp_is_end),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_payload_len  (rsp_payload_len),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is cut short here if the decoder stops delivering.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Bytes waiting to be put on the line, and the items the decoder owes us.
   octet_q_type  line_bytes;
   deframed_type deframed_due [$];
   int unsigned  queued_bytes = 0;
   int unsigned  mismatches   = 0;
   bit           byte_on_line = 1'b0;

   // Private copy of the decoder state, kept in step with every accepted byte.
   logic [15:0] sync_copy   = SYNC_RESET;
   logic [2:0]  hunt_phase  = PH_HUNT;
   logic [7:0]  win_byte    = 8'h00;
   logic        win_full    = 1'b0;
   logic [15:0] len_acc     = 16'h0000;
   logic [15:0] body_left   = 16'h0000;
   logic [7:0]  frame_kind  = 8'h00;
   logic [15:0] crc_acc     = CRC_INIT;
   logic [7:0]  crc_hi_seen = 8'h00;

   // CRC-16-CCITT, most significant bit first, taken one message bit at a time.
   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   // Advances the private state by one accepted byte and records any item it
   // should cause on the response channel.
   task automatic deframe_byte(input logic [7:0] b);
      deframed_type item;
      case (hunt_phase)
         PH_LEN_HI: begin
            len_acc    = {b, 8'h00};
            hunt_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_acc[7:0] = b;
            if (len_acc < MIN_LENGTH) begin
               // A short length drops only the sync word. If the length bytes
               // themselves form the sync word, a new length follows.
               if (len_acc == sync_copy) begin
                  hunt_phase = PH_LEN_HI;
                  win_full   = 1'b0;
               end else begin
                  hunt_phase = PH_HUNT;
                  win_byte   = b;
                  win_full   = 1'b1;
               end
            end else begin
               body_left  = len_acc - MIN_LENGTH;
               crc_acc    = CRC_INIT;
               hunt_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            frame_kind = b;
            crc_acc    = crc_step(crc_acc, b);
            hunt_phase = (body_left != 16'h0000) ? PH_PAYLOAD : PH_CRC_HI;
         end
         PH_PAYLOAD: begin
            crc_acc   = crc_step(crc_acc, b);
            body_left = body_left - 16'd1;
            if (body_left == 16'h0000) begin
               hunt_phase = PH_CRC_HI;
            end
            item.data        = b;
            item.frame_type  = frame_kind;
            item.is_end      = 1'b0;
            item.crc_ok      = 1'b0;
            item.payload_len = 16'h0000;
            deframed_due.push_back(item);
         end
         PH_CRC_HI: begin
            crc_hi_seen = b;
            hunt_phase  = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            item.data        = 8'h00;
            item.frame_type  = frame_kind;
            item.is_end      = 1'b1;
            item.crc_ok      = ({crc_hi_seen, b} == crc_acc);
            item.payload_len = len_acc - MIN_LENGTH;
            deframed_due.push_back(item);
            // The sliding window starts empty after every frame.
            hunt_phase = PH_HUNT;
            win_full   = 1'b0;
         end
         default: begin
            if (win_full && ({win_byte, b} == sync_copy)) begin
               hunt_phase = PH_LEN_HI;
               win_full   = 1'b0;
            end else begin
               hunt_phase = PH_HUNT;
               win_byte   = b;
               win_full   = 1'b1;
            end
         end
      endcase
   endtask

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $realtime, what);
      mismatches++;
   endtask

   // Driver: the next pending byte goes on the line once the drawn idle gap has
   // run out. The byte is held unchanged until the decoder accepts it. A single
   // nonblocking write of req_valid per edge keeps back-to-back items clean.
   int unsigned feed_gap = 0;
   bit          feed_calm = 1'b0;

   always @(posedge clock) begin : feed
      logic next_valid;
      if (reset) begin
         req_valid    <= 1'b0;
         feed_gap     = 0;
         byte_on_line = 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            deframe_byte(req_in_byte);
            next_valid   = 1'b0;
            byte_on_line = 1'b0;
         end
         if (!next_valid) begin
            if (feed_gap > 0) begin
               feed_gap--;
            end else if (line_bytes.size() > 0) begin
               req_in_byte  <= line_bytes.pop_front();
               next_valid   = 1'b1;
               byte_on_line = 1'b1;
               // Now and then switch between idle gaps and a flat-out stream.
               if ($urandom_range(0, 39) == 0) begin
                  feed_calm = !feed_calm;
               end
               feed_gap = feed_calm ? 0 : $urandom_range(0, 17);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: every accepted response item is held against the oldest one due.
   // After each item a stall length is drawn, with calm stretches in between.
   int unsigned sink_stall = 0;
   bit          sink_calm  = 1'b0;

   always @(posedge clock) begin : sink
      deframed_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (deframed_due.size() == 0) begin
               flag_mismatch($sformatf("item with nothing due (data %02h end %0b)",
                                       rsp_data, rsp_is_end));
            end else begin
               want = deframed_due.pop_front();
               if (rsp_data !== want.data)
                  flag_mismatch($sformatf("data %02h, wanted %02h", rsp_data, want.data));
               if (rsp_frame_type !== want.frame_type)
                  flag_mismatch($sformatf("frame_type %02h, wanted %02h",
                                          rsp_frame_type, want.frame_type));
               if (rsp_is_end !== want.is_end)
                  flag_mismatch($sformatf("is_end %0b, wanted %0b", rsp_is_end, want.is_end));
               if (rsp_crc_ok !== want.crc_ok)
                  flag_mismatch($sformatf("crc_ok %0b, wanted %0b", rsp_crc_ok, want.crc_ok));
               if (rsp_payload_len !== want.payload_len)
                  flag_mismatch($sformatf("payload_len %0d, wanted %0d",
                                          rsp_payload_len, want.payload_len));
            end
            if ($urandom_range(0, 39) == 0) begin
               sink_calm = !sink_calm;
            end
            sink_stall = sink_calm ? 0 : $urandom_range(0, 17);
         end
         if (sink_stall > 0) begin
            rsp_stall <= 1'b1;
            sink_stall--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic put(input logic [7:0] b);
      line_bytes.push_back(b);
      queued_bytes++;
   endtask

   // A whole frame: sync word, inner length, type, body and CRC. A spoilt
   // frame carries a CRC with at least one bit flipped.
   task automatic add_frame(input logic [15:0] sw, input logic [7:0] kind,
                            input octet_q_type body, input bit spoil);
      logic [15:0] c;
      logic [15:0] ilen;
      ilen = 16'(body.size() + 3);
      put(sw[15:8]);
      put(sw[7:0]);
      put(ilen[15:8]);
      put(ilen[7:0]);
      put(kind);
      c = crc_step(CRC_INIT, kind);
      foreach (body[i]) begin
         put(body[i]);
         c = crc_step(c, body[i]);
      end
      if (spoil) begin
         c = c ^ 16'($urandom_range(1, 65535));
      end
      put(c[15:8]);
      put(c[7:0]);
   endtask

   // A header whose length is too short to hold a frame.
   task automatic add_short_header(input logic [15:0] sw, input logic [7:0] len_lo);
      put(sw[15:8]);
      put(sw[7:0]);
      put(8'h00);
      put(len_lo);
   endtask

   // Mostly well-formed frames with random content, small bodies and now and then
   // a large one, mixed with short headers, bad CRCs and loose noise bytes.
   task automatic add_random_traffic(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      int unsigned body_size;
      octet_q_type body;
      start = queued_bytes;
      while (queued_bytes - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            body_size = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 300)
                                                     : $urandom_range(0, 12);
            body.delete();
            repeat (body_size) body.push_back(8'($urandom_range(0, 255)));
            add_frame(sync_copy, 8'($urandom_range(0, 255)), body,
                      $urandom_range(0, 4) == 0);
         end else if (pick < 82) begin
            add_short_header(sync_copy, 8'($urandom_range(0, 2)));
         end else begin
            repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Waits until every byte is taken and every item due has arrived, then
   // lets the clock run on before returning, since hunt bytes cause no item.
   task automatic settle();
      while (line_bytes.size() != 0 || byte_on_line || deframed_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_sync(input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      sync_copy        = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      octet_q_type body;
      logic [15:0] plan [6];

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset sync word: an empty frame with the
      // extreme type, a body holding both extreme bytes, a short length and
      // an empty frame whose CRC is wrong.
      body.delete();
      add_frame(sync_copy, 8'hFF, body, 1'b0);
      body.push_back(8'h00);
      body.push_back(8'hFF);
      add_frame(sync_copy, 8'h00, body, 1'b0);
      add_short_header(sync_copy, 8'h02);
      body.delete();
      add_frame(sync_copy, 8'h5A, body, 1'b1);
      add_random_traffic(30);
      settle();

      plan = '{16'h0002, 16'hFFFF, 16'h0000, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), SYNC_RESET};
      foreach (plan[p]) begin
         write_sync(plan[p]);
         if (plan[p] == 16'h0002) begin
            // The length bytes repeat the sync word, so a fresh length follows.
            put(8'h00);
            put(8'h02);
            body.delete();
            body.push_back(8'($urandom_range(0, 255)));
            add_frame(sync_copy, 8'($urandom_range(0, 255)), body, 1'b0);
         end
         add_random_traffic(30);
         settle();
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
